/* rtl/core/lphs_pkg.sv */
// ----------------------------------------------------------------------------
// lphs_pkg
// Shared sizes, codes and helpers of the linear probing hash set unit.
// ----------------------------------------------------------------------------
package lphs_pkg;

   // table geometry
   localparam int TABLE_SIZE = 32;
   localparam int KEY_BYTES  = 10;
   localparam int SLOT_W     = $clog2(TABLE_SIZE);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SIZE - 1);

   // byte sum of a whole key, and whether the modulo is a plain mask
   localparam int  SUM_W      = $clog2(KEY_BYTES * 255 + 1);
   localparam bit  TABLE_POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);

   // reciprocal of the table size, exact for every byte sum
   localparam int RECIP_SH = SUM_W + SLOT_W;
   localparam int RECIP    = (2 ** RECIP_SH + TABLE_SIZE - 1) / TABLE_SIZE;

   // payload widths fixed by the interface
   localparam int KEY_LO_W   = 64;
   localparam int KEY_HI_W   = 16;
   localparam int OP_W       = 2;
   localparam int STATUS_W   = 3;
   localparam int SLOT_OUT_W = 5;

   // operation codes (any other code is a membership test)
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_TEST   = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
   localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd5;

   // slot marks
   localparam logic [1:0] MARK_EMPTY = 2'd0;
   localparam logic [1:0] MARK_USED  = 2'd1;
   localparam logic [1:0] MARK_GONE  = 2'd2;

   // one table entry as held in memory
   typedef struct packed {
      logic [1:0]          mark;
      logic [KEY_HI_W-1:0] key_hi;
      logic [KEY_LO_W-1:0] key_lo;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // byte masks for keys shorter than ten bytes
   function automatic logic [KEY_LO_W-1:0] key_lo_mask();
      logic [KEY_LO_W-1:0] m;
      m = '0;
      for (int k = 0; k < 8; k++) begin
         if (k < KEY_BYTES) m[8*k +: 8] = 8'hff;
      end
      return m;
   endfunction

   function automatic logic [KEY_HI_W-1:0] key_hi_mask();
      logic [KEY_HI_W-1:0] m;
      m = '0;
      for (int k = 0; k < 2; k++) begin
         if (k + 8 < KEY_BYTES) m[8*k +: 8] = 8'hff;
      end
      return m;
   endfunction

   localparam logic [KEY_LO_W-1:0] KEY_LO_MASK = key_lo_mask();
   localparam logic [KEY_HI_W-1:0] KEY_HI_MASK = key_hi_mask();

   // sum of all ten key bytes
   function automatic logic [SUM_W-1:0] byte_sum(input logic [KEY_LO_W-1:0] lo,
                                                 input logic [KEY_HI_W-1:0] hi);
      logic [SUM_W-1:0] s;
      s = '0;
      for (int k = 0; k < 8; k++) begin
         s = s + SUM_W'(lo[8*k +: 8]);
      end
      for (int k = 0; k < 2; k++) begin
         s = s + SUM_W'(hi[8*k +: 8]);
      end
      return s;
   endfunction

endpackage

/* rtl/core/lphs_ram.sv */
// ----------------------------------------------------------------------------
// lphs_ram
// Generic single write, single read memory with a registered read.
// ----------------------------------------------------------------------------
module lphs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/linear_probe_hash_set_unit.sv */
// ----------------------------------------------------------------------------
// linear_probe_hash_set_unit
// Open addressing hash set of short keys with linear probing and tombstones.
// ----------------------------------------------------------------------------
// Each request inserts, tests or deletes one key of up to ten bytes; exactly
// one result comes back per request, in order. All slots live in one memory
// with a single read port, and the probe walks it one slot per cycle from the
// home slot (key byte sum modulo the table size). A request is taken in the
// idle state, which sums its bytes; the hash state finds the home slot and
// issues its read, the probe state checks the slots in turn and the done
// state loads the result register once it is free, before the unit returns
// to idle for the next request. The unit takes no new request until it is
// through with the last one. With a table size that is not a power of two
// the home slot is found by a reciprocal multiplication before the remainder.
// After reset a clearing pass marks every slot empty, during which no
// request is taken. A result waiting in the output register does not stop
// the next request from being taken.
module linear_probe_hash_set_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,  // key_low [63:0], key_high [79:64]
   input  logic [1:0]  req_tuser,  // op [1:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // slot [4:0], zero [7:5]
   output logic [2:0]  rsp_tuser   // status [2:0]
);

   localparam int SLOT_W = lphs_pkg::SLOT_W;
   localparam int SUM_W  = lphs_pkg::SUM_W;
   localparam int PROD_W = 2 * SUM_W + 1;

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_HASH  = 5'b00100,
      S_PROBE = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [lphs_pkg::OP_W-1:0]     op_ff, op_in;
   logic [lphs_pkg::KEY_LO_W-1:0] key_lo_ff, key_lo_in;
   logic [lphs_pkg::KEY_HI_W-1:0] key_hi_ff, key_hi_in;
   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic [SUM_W-1:0]              quo_ff, quo_in;
   logic                          quo_vld_ff, quo_vld_in;
   logic [SLOT_W-1:0]             clr_ff, clr_in;
   logic [SLOT_W-1:0]             cur_ff, cur_in;
   logic [SLOT_W-1:0]             cnt_ff, cnt_in;
   logic                          free_vld_ff, free_vld_in;
   logic [SLOT_W-1:0]             free_ff, free_in;
   logic [lphs_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [SLOT_W-1:0]             res_slot_ff, res_slot_in;
   logic                          rsp_vld_ff, rsp_vld_in;
   logic [lphs_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [lphs_pkg::SLOT_OUT_W-1:0] rsp_slot_ff, rsp_slot_in;

   // memory ports
   logic                  wr_en;
   logic [SLOT_W-1:0]     wr_addr;
   lphs_pkg::entry_type   wr_entry;
   logic [SLOT_W-1:0]     rd_addr;
   lphs_pkg::entry_type   rd_entry;
   logic [lphs_pkg::ENTRY_W-1:0] rd_raw;

   lphs_ram #(
      .WIDTH (lphs_pkg::ENTRY_W),
      .DEPTH (lphs_pkg::TABLE_SIZE)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_entry = lphs_pkg::entry_type'(rd_raw);

   // probe decode of the slot just read
   logic [SLOT_W-1:0] next_slot;
   logic [PROD_W-1:0] quo_prod;
   logic [SLOT_W-1:0] home_rem;
   logic              slot_used, slot_empty, slot_hit, probe_last;
   logic              any_free;
   logic [SLOT_W-1:0] any_free_slot;

   assign next_slot  = (cur_ff == lphs_pkg::LAST_SLOT) ? '0 : cur_ff + 1'b1;
   assign slot_used  = (rd_entry.mark == lphs_pkg::MARK_USED);
   assign slot_empty = (rd_entry.mark == lphs_pkg::MARK_EMPTY);
   assign slot_hit   = slot_used && (rd_entry.key_lo == key_lo_ff)
                                 && (rd_entry.key_hi == key_hi_ff);
   assign probe_last = (cnt_ff == lphs_pkg::LAST_SLOT);
   assign any_free      = free_vld_ff || !slot_used;
   assign any_free_slot = free_vld_ff ? free_ff : cur_ff;

   // home slot remainder from the quotient by reciprocal multiplication
   assign quo_prod = PROD_W'(sum_ff) * PROD_W'(lphs_pkg::RECIP);
   assign home_rem = SLOT_W'(sum_ff - SUM_W'(quo_ff * SUM_W'(lphs_pkg::TABLE_SIZE)));

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_lo_in     = key_lo_ff;
      key_hi_in     = key_hi_ff;
      sum_in        = sum_ff;
      quo_in        = quo_ff;
      quo_vld_in    = quo_vld_ff;
      clr_in        = clr_ff;
      cur_in        = cur_ff;
      cnt_in        = cnt_ff;
      free_vld_in   = free_vld_ff;
      free_in       = free_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      wr_en         = 1'b0;
      wr_addr       = cur_ff;
      wr_entry      = '{mark: lphs_pkg::MARK_USED, key_hi: key_hi_ff, key_lo: key_lo_ff};
      rd_addr       = next_slot;

      case (state_ff)
         // mark every slot empty after reset
         S_CLEAR: begin
            wr_en    = 1'b1;
            wr_addr  = clr_ff;
            wr_entry = '{mark: lphs_pkg::MARK_EMPTY, key_hi: '0, key_lo: '0};
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == lphs_pkg::LAST_SLOT) state_in = S_IDLE;
         end

         // take a request and sum its bytes
         S_IDLE: begin
            if (req_tvalid) begin
               op_in      = req_tuser;
               key_lo_in  = req_tdata[63:0]  & lphs_pkg::KEY_LO_MASK;
               key_hi_in  = req_tdata[79:64] & lphs_pkg::KEY_HI_MASK;
               sum_in     = lphs_pkg::byte_sum(req_tdata[63:0]  & lphs_pkg::KEY_LO_MASK,
                                               req_tdata[79:64] & lphs_pkg::KEY_HI_MASK);
               quo_vld_in = 1'b0;
               state_in   = S_HASH;
            end
         end

         // home slot, then first read of the probe
         S_HASH: begin
            if (lphs_pkg::TABLE_POW2 || quo_vld_ff) begin
               cur_in      = lphs_pkg::TABLE_POW2 ? SLOT_W'(sum_ff) : home_rem;
               rd_addr     = cur_in;
               cnt_in      = '0;
               free_vld_in = 1'b0;
               state_in    = S_PROBE;
            end else begin
               quo_in     = SUM_W'(quo_prod >> lphs_pkg::RECIP_SH);
               quo_vld_in = 1'b1;
            end
         end

         // one slot per cycle, next read already issued
         S_PROBE: begin
            cur_in   = next_slot;
            cnt_in   = cnt_ff + 1'b1;
            case (op_ff)
               lphs_pkg::OP_INSERT: begin
                  if (slot_hit) begin
                     res_status_in = lphs_pkg::ST_PRESENT;
                     res_slot_in   = cur_ff;
                     state_in      = S_DONE;
                  end else if (slot_empty || probe_last) begin
                     if (any_free) begin
                        wr_en         = 1'b1;
                        wr_addr       = any_free_slot;
                        res_status_in = lphs_pkg::ST_INSERTED;
                        res_slot_in   = any_free_slot;
                     end else begin
                        res_status_in = lphs_pkg::ST_FULL;
                        res_slot_in   = '0;
                     end
                     state_in = S_DONE;
                  end else if (!free_vld_ff && !slot_used) begin
                     free_vld_in = 1'b1;
                     free_in     = cur_ff;
                  end
               end

               lphs_pkg::OP_DELETE: begin
                  if (slot_hit) begin
                     wr_en         = 1'b1;
                     wr_addr       = cur_ff;
                     wr_entry.mark = lphs_pkg::MARK_GONE;
                     res_status_in = lphs_pkg::ST_DELETED;
                     res_slot_in   = cur_ff;
                     state_in      = S_DONE;
                  end else if (probe_last) begin
                     res_status_in = lphs_pkg::ST_NOT_FOUND;
                     res_slot_in   = '0;
                     state_in      = S_DONE;
                  end
               end

               // membership test, also for the unused code
               default: begin
                  if (slot_hit) begin
                     res_status_in = lphs_pkg::ST_FOUND;
                     res_slot_in   = cur_ff;
                     state_in      = S_DONE;
                  end else if (slot_empty || probe_last) begin
                     res_status_in = lphs_pkg::ST_NOT_FOUND;
                     res_slot_in   = '0;
                     state_in      = S_DONE;
                  end
               end
            endcase
         end

         // hand the result to the output register once it is free
         S_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in    = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = lphs_pkg::SLOT_OUT_W'(res_slot_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_lo_ff     <= key_lo_in;
      key_hi_ff     <= key_hi_in;
      sum_ff        <= sum_in;
      quo_ff        <= quo_in;
      quo_vld_ff    <= quo_vld_in;
      cur_ff        <= cur_in;
      cnt_ff        <= cnt_in;
      free_vld_ff   <= free_vld_in;
      free_ff       <= free_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   // ports
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_slot_ff};

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench of the linear probing hash set unit.
// ----------------------------------------------------------------------------
// Requests (insert, test, delete) are fed from a queue to a stream driver.
// A shadow copy of the table works out status and slot for each request at
// the moment it is taken, and the result monitor checks them in order.
// A directed opening covers key extremes, collisions, wraparound and
// tombstones. Random rounds then fill the table past full and drain it
// again, with a shared key pool so that keys collide and repeat.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int HALF_PERIOD  = 2;
   localparam int RESET_CYCLES = 9;
   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int ROUNDS       = 8;
   localparam int POOL_KEYS    = 40;
   localparam int POOL_W       = $clog2(POOL_KEYS);
   localparam int REFRESH_KEYS = 10;

   // spare op code, handled as a membership test
   localparam logic [lphs_pkg::OP_W-1:0] OP_SPARE = 2'd3;

   typedef struct {
      logic [lphs_pkg::OP_W-1:0]     op;
      logic [lphs_pkg::KEY_LO_W-1:0] key_lo;
      logic [lphs_pkg::KEY_HI_W-1:0] key_hi;
   } key_request_type;

   typedef struct {
      logic [lphs_pkg::STATUS_W-1:0]   status;
      logic [lphs_pkg::SLOT_OUT_W-1:0] slot;
   } set_outcome_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata  = '0;  // key_low [63:0], key_high [79:64]
   logic [1:0]  req_tuser  = '0;  // op [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // slot [4:0], zero [7:5]
   logic [2:0]  rsp_tuser;        // status [2:0]

   // shadow of the table, all slots empty after reset
   logic [1:0] shadow_mark [lphs_pkg::TABLE_SIZE] = '{default: lphs_pkg::MARK_EMPTY};
   logic [lphs_pkg::KEY_LO_W-1:0] shadow_lo [lphs_pkg::TABLE_SIZE];
   logic [lphs_pkg::KEY_HI_W-1:0] shadow_hi [lphs_pkg::TABLE_SIZE];

   // key pool shared by the random rounds
   logic [lphs_pkg::KEY_LO_W-1:0] pool_lo [POOL_KEYS];
   logic [lphs_pkg::KEY_HI_W-1:0] pool_hi [POOL_KEYS];

   key_request_type key_requests [$];
   set_outcome_type set_outcomes [$];
   int              requests_queued = 0;
   int              requests_sent   = 0;
   int              requests_taken  = 0;
   int              mismatches      = 0;
   int              cycle_count     = 0;
   bit              steady_flow     = 1'b0;

   linear_probe_hash_set_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #HALF_PERIOD clock = ~clock;

   // applies one request to the shadow table and returns its outcome
   function automatic set_outcome_type apply_set_op(key_request_type rq);
      set_outcome_type               res;
      logic [lphs_pkg::KEY_LO_W-1:0] lo;
      logic [lphs_pkg::KEY_HI_W-1:0] hi;
      int                            total;
      int                            home;
      logic [lphs_pkg::SLOT_W-1:0]   s;
      int                            hit;
      lo    = rq.key_lo & lphs_pkg::KEY_LO_MASK;
      hi    = rq.key_hi & lphs_pkg::KEY_HI_MASK;
      total = 0;
      for (int b = 0; b < 8; b++) total += int'(lo[8*b +: 8]);
      for (int b = 0; b < 2; b++) total += int'(hi[8*b +: 8]);
      home  = total % lphs_pkg::TABLE_SIZE;
      res.status = lphs_pkg::ST_NOT_FOUND;
      res.slot   = '0;
      // lookup walk: over tombstones, stops at an empty slot
      hit = -1;
      for (int i = 0; i < lphs_pkg::TABLE_SIZE; i++) begin
         s = lphs_pkg::SLOT_W'((home + i) % lphs_pkg::TABLE_SIZE);
         if (shadow_mark[s] == lphs_pkg::MARK_EMPTY) break;
         if (shadow_mark[s] == lphs_pkg::MARK_USED && shadow_lo[s] == lo &&
             shadow_hi[s] == hi) begin
            hit = int'(s);
            break;
         end
      end
      case (rq.op)
         lphs_pkg::OP_INSERT: begin
            if (hit >= 0) begin
               res.status = lphs_pkg::ST_PRESENT;
               res.slot   = lphs_pkg::SLOT_OUT_W'(hit);
            end else begin
               res.status = lphs_pkg::ST_FULL;
               for (int i = 0; i < lphs_pkg::TABLE_SIZE; i++) begin
                  s = lphs_pkg::SLOT_W'((home + i) % lphs_pkg::TABLE_SIZE);
                  if (shadow_mark[s] != lphs_pkg::MARK_USED) begin
                     shadow_mark[s] = lphs_pkg::MARK_USED;
                     shadow_lo[s]   = lo;
                     shadow_hi[s]   = hi;
                     res.status     = lphs_pkg::ST_INSERTED;
                     res.slot       = lphs_pkg::SLOT_OUT_W'(s);
                     break;
                  end
               end
            end
         end
         lphs_pkg::OP_DELETE: begin
            // delete looks at every slot, empty ones included
            for (int i = 0; i < lphs_pkg::TABLE_SIZE; i++) begin
               s = lphs_pkg::SLOT_W'((home + i) % lphs_pkg::TABLE_SIZE);
               if (shadow_mark[s] == lphs_pkg::MARK_USED && shadow_lo[s] == lo &&
                   shadow_hi[s] == hi) begin
                  shadow_mark[s] = lphs_pkg::MARK_GONE;
                  res.status     = lphs_pkg::ST_DELETED;
                  res.slot       = lphs_pkg::SLOT_OUT_W'(s);
                  break;
               end
            end
         end
         default: begin
            if (hit >= 0) begin
               res.status = lphs_pkg::ST_FOUND;
               res.slot   = lphs_pkg::SLOT_OUT_W'(hit);
            end
         end
      endcase
      return res;
   endfunction

   task automatic push_request(input logic [lphs_pkg::OP_W-1:0] op,
                               input logic [lphs_pkg::KEY_LO_W-1:0] lo,
                               input logic [lphs_pkg::KEY_HI_W-1:0] hi);
      key_request_type rq;
      rq.op     = op;
      rq.key_lo = lo;
      rq.key_hi = hi;
      key_requests.push_back(rq);
      requests_queued++;
   endtask

   // new pool key: wide random, sparse small bytes, or a byte swap of another
   function automatic void fresh_key(input int j, input int span);
      int                            kind;
      int                            src;
      int                            a;
      int                            b;
      logic [7:0]                    tmp;
      logic [lphs_pkg::KEY_LO_W-1:0] lo;
      logic [lphs_pkg::KEY_HI_W-1:0] hi;
      kind = $urandom_range(2);
      lo   = {$urandom, $urandom};
      hi   = 16'($urandom);
      if (kind == 1) begin
         for (int k = 0; k < 8; k++)
            lo[8*k +: 8] = ($urandom_range(9) < 7) ? 8'd0 : 8'($urandom_range(15));
         for (int k = 0; k < 2; k++)
            hi[8*k +: 8] = ($urandom_range(9) < 7) ? 8'd0 : 8'($urandom_range(15));
      end else if (kind == 2 && span > 0) begin
         // same byte sum, so same home slot
         src = $urandom_range(span - 1);
         lo  = pool_lo[POOL_W'(src)];
         hi  = pool_hi[POOL_W'(src)];
         a   = $urandom_range(7);
         b   = $urandom_range(7);
         tmp = lo[8*a +: 8];
         lo[8*a +: 8] = lo[8*b +: 8];
         lo[8*b +: 8] = tmp;
      end
      pool_lo[POOL_W'(j)] = lo;
      pool_hi[POOL_W'(j)] = hi;
   endfunction

   // random requests over the pool with a given op mix, some noise keys
   task automatic random_phase(input int count, input int ins_pct, input int tst_pct,
                               input int del_pct);
      int                        roll;
      int                        pick;
      logic [lphs_pkg::OP_W-1:0] op;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < ins_pct) op = lphs_pkg::OP_INSERT;
         else if (roll < ins_pct + tst_pct) op = lphs_pkg::OP_TEST;
         else if (roll < ins_pct + tst_pct + del_pct) op = lphs_pkg::OP_DELETE;
         else op = OP_SPARE;
         if ($urandom_range(99) < 8) begin
            push_request(op, {$urandom, $urandom}, 16'($urandom));
         end else begin
            pick = $urandom_range(POOL_KEYS - 1);
            push_request(op, pool_lo[POOL_W'(pick)], pool_hi[POOL_W'(pick)]);
         end
      end
   endtask

   task automatic wait_idle();
      while (requests_taken != requests_queued || set_outcomes.size() != 0)
         @(negedge clock);
   endtask

   // stimulus
   initial begin
      int j;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed opening
      push_request(lphs_pkg::OP_TEST,   '0, '0);                 // empty table
      push_request(lphs_pkg::OP_INSERT, '0, '0);                 // all-zero key
      push_request(lphs_pkg::OP_INSERT, '0, '0);                 // already present
      push_request(lphs_pkg::OP_INSERT, '1, '1);                 // all-ones key
      push_request(lphs_pkg::OP_TEST,   '1, '1);
      push_request(OP_SPARE,            '1, '1);                 // spare code tests
      push_request(lphs_pkg::OP_DELETE, '1, '1);
      push_request(lphs_pkg::OP_DELETE, '1, '1);                 // delete of absent key
      push_request(lphs_pkg::OP_TEST,   '1, '1);                 // tombstone then empty
      push_request(lphs_pkg::OP_INSERT, 64'h20, '0);             // collisions at home 0
      push_request(lphs_pkg::OP_INSERT, 64'h1f01, '0);
      push_request(lphs_pkg::OP_INSERT, '0, 16'h0020);
      push_request(lphs_pkg::OP_DELETE, '0, '0);                 // tombstone at home 0
      push_request(lphs_pkg::OP_TEST,   64'h1f01, '0);           // walk over tombstone
      push_request(lphs_pkg::OP_INSERT, 64'h1f01, '0);           // present past tombstone
      push_request(lphs_pkg::OP_INSERT, 64'h2000, '0);           // reuses the tombstone
      push_request(lphs_pkg::OP_DELETE, '0, 16'h0020);
      push_request(lphs_pkg::OP_TEST,   '0, 16'h0020);
      push_request(lphs_pkg::OP_INSERT, 64'h1f, '0);             // home 31
      push_request(lphs_pkg::OP_INSERT, 64'h1e01, '0);           // wraps round to slot 0 on
      push_request(lphs_pkg::OP_INSERT, 64'h8000_0000_0000_0001, 16'h8000);
      wait_idle();

      // random rounds: fill past full, then drain
      for (int k = 0; k < POOL_KEYS; k++) fresh_key(k, k);
      for (int r = 0; r < ROUNDS; r++) begin
         steady_flow = (r == ROUNDS / 2);
         if (r > 0) begin
            // retire part of the pool so stale keys do not clog the table
            for (int k = 0; k < REFRESH_KEYS; k++) begin
               j = $urandom_range(POOL_KEYS - 1);
               push_request(lphs_pkg::OP_DELETE, pool_lo[POOL_W'(j)], pool_hi[POOL_W'(j)]);
               fresh_key(j, POOL_KEYS);
            end
         end
         random_phase(60, 75, 13, 7);
         random_phase(50, 12, 30, 50);
         // sender holds off until every result is back
         wait_idle();
      end
      steady_flow = 1'b0;

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // request driver, next request once the current one has been taken
   always @(negedge clock) begin : request_drive
      key_request_type next_rq;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || requests_taken == requests_sent) begin
         if (key_requests.size() != 0 && (steady_flow || $urandom_range(99) >= 20)) begin
            next_rq = key_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {next_rq.key_hi, next_rq.key_lo};
            req_tuser  <= next_rq.op;
            requests_sent++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      rsp_tready <= steady_flow || ($urandom_range(99) >= 20);
   end

   // result check and request capture
   always @(posedge clock) begin : result_check
      set_outcome_type want;
      key_request_type rq;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (set_outcomes.size() == 0) begin
            mismatches++;
            $display("%0t: result expected none, got status %0d slot %0d",
                     $time, rsp_tuser, rsp_tdata);
         end else begin
            want = set_outcomes.pop_front();
            if (rsp_tuser !== want.status) begin
               mismatches++;
               $display("%0t: status expected %0d, got %0d", $time, want.status, rsp_tuser);
            end
            if (rsp_tdata !== {3'b000, want.slot}) begin
               mismatches++;
               $display("%0t: slot expected %0d, got %0d", $time, want.slot, rsp_tdata);
            end
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         rq.op     = req_tuser;
         rq.key_lo = req_tdata[63:0];
         rq.key_hi = req_tdata[79:64];
         set_outcomes.push_back(apply_set_op(rq));
         requests_taken++;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

endmodule
